[rtl/json_string_unescape_defines.svh]
// ----------------------------------------------------------------------------
// json string unescape assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JSU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("json_string_unescape check failed");

// next-cycle implication, sampled on clk, off during reset
`define JSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("json_string_unescape check failed");

`endif

[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// codes, character constants and types shared by the string unescape block
// ----------------------------------------------------------------------------
package jsu_pkg;

	// parser phase codes
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_NU   = 4'd1;
	localparam logic [3:0] PH_NL1  = 4'd2;
	localparam logic [3:0] PH_NL2  = 4'd3;
	localparam logic [3:0] PH_STR  = 4'd4;
	localparam logic [3:0] PH_ESC  = 4'd5;
	localparam logic [3:0] PH_HEX  = 4'd6;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_NULL = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	// input characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_L   = 8'h6C;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_LC_A   = 8'h61;

	// control codes produced by escapes
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_TAB = 8'h09;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_CR  = 8'h0D;

	// one parse step outcome
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic [1:0] kind;
	} result_t;

	// {ok, nibble} for one hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			d = c - CH_DIG_0;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_UC_A && c <= CH_UC_F) begin
			d = c - CH_UC_A + 8'd10;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_LC_A && c <= CH_LC_F) begin
			d = c - CH_LC_A + 8'd10;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

endpackage

[rtl/jsu_parser.sv]
// ----------------------------------------------------------------------------
// jsu_parser
// per-byte state machine: null literal, quoted string, escapes and \u digits
// ----------------------------------------------------------------------------
module jsu_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       cur_byte,
	output jsu_pkg::result_t res
);
	import jsu_pkg::*;

	logic [3:0]  phase_q;
	logic [15:0] hex_accum_q;
	logic [1:0]  hex_count_q;

	logic [3:0]  phase_d;
	logic [15:0] hex_accum_d;
	logic [1:0]  hex_count_d;
	logic [4:0]  hex;
	logic [15:0] hex_shift;

	assign hex       = hex_digit(cur_byte);
	assign hex_shift = {hex_accum_q[11:0], hex[3:0]};

	always_comb begin
		phase_d     = phase_q;
		hex_accum_d = hex_accum_q;
		hex_count_d = hex_count_q;
		res         = '{valid: 1'b0, ch: 8'd0, kind: KIND_CHAR};
		unique case (phase_q)
			PH_NU: begin
				if (cur_byte == CH_LC_U) begin
					phase_d = PH_NL1;
				end else begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				end
			end
			PH_NL1: begin
				if (cur_byte == CH_LC_L) begin
					phase_d = PH_NL2;
				end else begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				end
			end
			PH_NL2: begin
				if (cur_byte == CH_LC_L) begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_NULL};
				end else begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				end
			end
			PH_STR: begin
				priority if (cur_byte == CH_QUOTE) begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_END};
				end else if (cur_byte == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					res = '{valid: 1'b1, ch: cur_byte, kind: KIND_CHAR};
				end
			end
			PH_ESC: begin
				phase_d = PH_STR;
				unique case (cur_byte)
					CH_QUOTE, CH_BSLASH, CH_SLASH:
						res = '{valid: 1'b1, ch: cur_byte, kind: KIND_CHAR};
					CH_LC_B: res = '{valid: 1'b1, ch: CC_BS, kind: KIND_CHAR};
					CH_LC_F: res = '{valid: 1'b1, ch: CC_FF, kind: KIND_CHAR};
					CH_LC_N: res = '{valid: 1'b1, ch: CC_LF, kind: KIND_CHAR};
					CH_LC_R: res = '{valid: 1'b1, ch: CC_CR, kind: KIND_CHAR};
					CH_LC_T: res = '{valid: 1'b1, ch: CC_TAB, kind: KIND_CHAR};
					CH_LC_U: begin
						phase_d     = PH_HEX;
						hex_accum_d = 16'd0;
						hex_count_d = 2'd0;
					end
					default: res = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				endcase
			end
			PH_HEX: begin
				if (!hex[4]) begin
					res = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				end else begin
					hex_accum_d = hex_shift;
					hex_count_d = hex_count_q + 2'd1;
					// fourth digit: only the low byte of the code unit goes out
					if (hex_count_q == 2'd3) begin
						phase_d = PH_STR;
						res     = '{valid: 1'b1, ch: hex_shift[7:0], kind: KIND_CHAR};
					end
				end
			end
			default: begin
				// idle and unused codes
				priority if (cur_byte == CH_LC_N) begin
					phase_d = PH_NU;
				end else if (cur_byte == CH_QUOTE) begin
					phase_d = PH_STR;
				end else begin
					phase_d = PH_IDLE;
					res     = '{valid: 1'b1, ch: 8'd0, kind: KIND_ERR};
				end
			end
		endcase
		// any end or error result drops back to idle
		if (res.valid && res.kind != KIND_CHAR) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hex_accum_q <= 16'd0;
			hex_count_q <= 2'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			hex_accum_q <= hex_accum_d;
			hex_count_q <= hex_count_d;
		end
	end

endmodule

[rtl/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape
// byte-serial decoder for one JSON string value or the literal null
// ----------------------------------------------------------------------------
// Input channel: one raw byte per beat on in_byte (in_valid / in_stall).
// Output channel: zero or one result per input byte on out_char, kind and
// last (out_valid / out_stall). kind is character, string end, null accepted
// or syntax error; last marks the three ending kinds. After an end or an
// error the parser is idle and waits for the next value start.
// Order: a byte is held in the input register, then its result is loaded
// into the result register.
// Throughput: one byte per cycle unless out_stall holds a result; the parser
// state is updated as the byte leaves the input register for the result register.
// When out_stall is held the result register keeps its beat, the stage behind
// it fills, and in_stall rises while a byte waits in the input register.
// Bytes that produce no result (quote, backslash, hex digits, n u l) also
// wait for the result register to be free before they move on.
// Reset (arst_n low) empties both registers and returns the parser to idle.
// ----------------------------------------------------------------------------
`include "json_string_unescape_defines.svh"

module json_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic [1:0] kind,
	output logic       last
);
	import jsu_pkg::*;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       out_free;
	logic       advance;
	result_t    res;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = in_valid_s1 && out_free;
	assign in_stall = in_valid_s1 && !out_free;

	jsu_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cur_byte (in_byte_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				in_valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= advance && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_byte_s1 <= in_byte;
		end
		if (out_free && advance && res.valid) begin
			out_char_q <= res.ch;
			kind_q     <= res.kind;
			last_q     <= (res.kind != KIND_CHAR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign kind      = kind_q;
	assign last      = last_q;

	`JSU_ASSERT_NOW(a_end_beat_fields, out_valid && kind != KIND_CHAR, last && out_char == 8'd0)
	`JSU_ASSERT_NOW(a_char_not_last, out_valid && kind == KIND_CHAR, !last)
	`JSU_ASSERT_NOW(a_stall_only_when_held, in_stall, in_valid_s1 && out_valid && out_stall)
	`JSU_ASSERT_NEXT(a_taken_beat_leaves, out_valid && !out_stall && !in_valid_s1, !out_valid)

endmodule
